// ----- src/rfa_pkg.sv -----
`timescale 1ns / 1ps

package rfa_pkg;

  // state of one seat around the ring
  typedef enum logic [1:0] {
    SEAT_THINK  = 2'd0,
    SEAT_HUNGRY = 2'd1,
    SEAT_EAT    = 2'd2
  } seat_state_e;

  // what an input word asks for
  typedef enum logic {
    KIND_TAKE = 1'b0,
    KIND_PUT  = 1'b1
  } kind_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD_C,
    ST_RD_L,
    ST_RD_R,
    ST_EVAL,
    ST_EMIT
  } rfa_state_e;

  localparam int unsigned CfgWidth  = 5;
  localparam int unsigned SeatWidth = 4;
  localparam int unsigned DataWidth = 8;
  localparam logic [CfgWidth-1:0] SeatsReset = 5'd16;

endpackage

// ----- src/ring_fork_arbiter.sv -----
`timescale 1ns / 1ps
// ring fork arbiter: one seat-state memory, one neighbor unit and a small sequencer
// sequence: a request marks its seat hungry, then that seat and both its neighbors are read
// and tested and any grant is emitted; a release marks its seat thinking and tests its
// left, then its right neighbor; an item outside the ring retires at once, one with no
// grant after its tests
// one item at a time: no new word is taken until the last one has retired
// reset: all seats thinking (valid bits cleared at once), seats_in_use back to 16

module ring_fork_arbiter import rfa_pkg::*; #(
  parameter int unsigned MAX_SEATS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write channel: seats_in_use
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgWidth-1:0]  cfg_wdata_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DataWidth-1:0] s_axis_tdata,   // [3:0] seat, rest zero
  input  logic [0:0]           s_axis_tuser,   // [0] kind
  // grant stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DataWidth-1:0] m_axis_tdata,   // [3:0] granted_seat, rest zero
  output logic                 m_axis_tlast    // final grant of this word
);

  localparam int unsigned SW = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
  localparam int unsigned NW = $clog2(MAX_SEATS + 1);
  localparam int unsigned CW = (NW > CfgWidth) ? NW : CfgWidth;

  // configuration register; writes must come only while idle, which the block does not enforce
  logic [CfgWidth-1:0] seats_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seats_q <= SeatsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      seats_q <= cfg_wdata_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // effective ring size: register saturated to 2 .. MAX_SEATS
  logic [CW-1:0] cfg_ext;
  logic [NW-1:0] ring_n;
  logic [CW-1:0] seat_ext;
  logic          in_ring;

  always_comb begin
    cfg_ext = CW'(seats_q);
    if (cfg_ext < CW'(2)) begin
      ring_n = NW'(2);
    end else if (cfg_ext > CW'(MAX_SEATS)) begin
      ring_n = NW'(MAX_SEATS);
    end else begin
      ring_n = NW'(cfg_ext);
    end
    seat_ext = CW'(s_axis_tdata[SeatWidth-1:0]);
    in_ring  = seat_ext < CW'(ring_n);
  end

  // sequencer registers
  rfa_state_e      state_q, state_d;
  kind_e           kind_q, kind_d;
  logic [SW-1:0]   seat_q, seat_d;
  logic [NW-1:0]   n_q, n_d;
  logic [SW-1:0]   tgt_q, tgt_d;
  logic            second_q, second_d;   // working on the right neighbor of a release
  seat_state_e     cur_q, cur_d;
  seat_state_e     lft_q, lft_d;
  logic            g0_v_q, g0_v_d;
  logic [SW-1:0]   g0_q, g0_d;
  logic            g1_v_q, g1_v_d;
  logic [SW-1:0]   g1_q, g1_d;
  logic            sel_q, sel_d;          // which grant word is on the output

  // shared neighbor unit and state memory hookup
  logic [SW-1:0]   nbr_base;
  logic            nbr_right;
  logic [SW-1:0]   nbr;
  logic            mem_we;
  logic [SW-1:0]   mem_waddr;
  seat_state_e     mem_wdata;
  logic [SW-1:0]   mem_raddr;
  seat_state_e     mem_rdata;
  logic            grant;
  logic [SW-1:0]   out_seat;

  rfa_nbr_unit #(
    .SeatW  (SW),
    .CountW (NW)
  ) u_nbr (
    .base_i  (nbr_base),
    .right_i (nbr_right),
    .count_i (n_q),
    .nbr_o   (nbr)
  );

  rfa_state_mem #(
    .Depth (MAX_SEATS),
    .AddrW (SW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      second_q <= 1'b0;
      g0_v_q   <= 1'b0;
      g1_v_q   <= 1'b0;
      sel_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
      g0_v_q   <= g0_v_d;
      g1_v_q   <= g1_v_d;
      sel_q    <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    seat_q <= seat_d;
    n_q    <= n_d;
    tgt_q  <= tgt_d;
    cur_q  <= cur_d;
    lft_q  <= lft_d;
    g0_q   <= g0_d;
    g1_q   <= g1_d;
  end

  // hungry and neither neighbor eating; right neighbor arrives from memory now
  assign grant = (cur_q == SEAT_HUNGRY) && (lft_q != SEAT_EAT) && (mem_rdata != SEAT_EAT);

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    seat_d    = seat_q;
    n_d       = n_q;
    tgt_d     = tgt_q;
    second_d  = second_q;
    cur_d     = cur_q;
    lft_d     = lft_q;
    g0_v_d    = g0_v_q;
    g0_d      = g0_q;
    g1_v_d    = g1_v_q;
    g1_d      = g1_q;
    sel_d     = sel_q;
    nbr_base  = tgt_q;
    nbr_right = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = tgt_q;
    mem_wdata = SEAT_EAT;
    mem_raddr = tgt_q;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          kind_d   = kind_e'(s_axis_tuser[0]);
          seat_d   = SW'(s_axis_tdata[SeatWidth-1:0]);
          n_d      = ring_n;
          second_d = 1'b0;
          g0_v_d   = 1'b0;
          g1_v_d   = 1'b0;
          sel_d    = 1'b0;
          // seats outside the ring are dropped here
          state_d  = in_ring ? ST_WRITE : ST_IDLE;
        end
      end
      ST_WRITE: begin
        // mark the seat, pick the first seat to test
        mem_we    = 1'b1;
        mem_waddr = seat_q;
        mem_wdata = (kind_q == KIND_PUT) ? SEAT_THINK : SEAT_HUNGRY;
        nbr_base  = seat_q;
        nbr_right = 1'b0;
        tgt_d     = (kind_q == KIND_PUT) ? nbr : seat_q;
        state_d   = ST_RD_C;
      end
      ST_RD_C: begin
        mem_raddr = tgt_q;
        state_d   = ST_RD_L;
      end
      ST_RD_L: begin
        nbr_right = 1'b0;
        mem_raddr = nbr;
        cur_d     = mem_rdata;
        state_d   = ST_RD_R;
      end
      ST_RD_R: begin
        nbr_right = 1'b1;
        mem_raddr = nbr;
        lft_d     = mem_rdata;
        state_d   = ST_EVAL;
      end
      ST_EVAL: begin
        mem_we    = grant;
        mem_waddr = tgt_q;
        mem_wdata = SEAT_EAT;
        if (grant) begin
          if (!g0_v_q) begin
            g0_v_d = 1'b1;
            g0_d   = tgt_q;
          end else begin
            g1_v_d = 1'b1;
            g1_d   = tgt_q;
          end
        end
        // a release goes on to its right neighbor
        nbr_base  = seat_q;
        nbr_right = 1'b1;
        if ((kind_q == KIND_PUT) && !second_q) begin
          second_d = 1'b1;
          tgt_d    = nbr;
          state_d  = ST_RD_C;
        end else begin
          state_d  = (grant || g0_v_q) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if (!sel_q && g1_v_q) begin
            sel_d = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_seat     = sel_q ? g1_q : g0_q;
  assign m_axis_tdata = DataWidth'(SeatWidth'(out_seat));
  assign m_axis_tlast = sel_q || !g1_v_q;

  // input and output never both open
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while a grant word is pending");

  // the second grant word only exists when a second grant was recorded
  a_second_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && sel_q) |-> (g1_v_q && g0_v_q))
    else $error("second grant word without a second grant");

  // only a release can grant twice
  a_two_only_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g1_v_q |-> (kind_q == KIND_PUT))
    else $error("two grants from a request");

  // a seat outside the ring retires without any work
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !in_ring) |=> (state_q == ST_IDLE))
    else $error("out-of-ring seat was processed");

  // tested seat always lies inside the ring
  a_tgt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_C || state_q == ST_RD_L || state_q == ST_RD_R ||
     state_q == ST_EVAL) |-> (NW'(tgt_q) < n_q))
    else $error("tested seat outside the ring");

endmodule

// ----- src/rfa_state_mem.sv -----
`timescale 1ns / 1ps

module rfa_state_mem import rfa_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  seat_state_e      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output seat_state_e      rdata_o
);

  seat_state_e mem_q [Depth];
  logic [Depth-1:0] vld_q;
  seat_state_e rdata_q;

  // per-entry valid bits: an unwritten seat reads as thinking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= vld_q[raddr_i] ? mem_q[raddr_i] : SEAT_THINK;
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rfa_nbr_unit.sv -----
`timescale 1ns / 1ps

module rfa_nbr_unit #(
  parameter int unsigned SeatW  = 4,
  parameter int unsigned CountW = 5
) (
  input  logic [SeatW-1:0]  base_i,
  input  logic              right_i,
  input  logic [CountW-1:0] count_i,
  output logic [SeatW-1:0]  nbr_o
);

  logic [CountW-1:0] inc;

  // one increment/decrement with wrap at the ring size
  always_comb begin
    inc = CountW'(base_i) + CountW'(1);
    if (right_i) begin
      nbr_o = (inc == count_i) ? '0 : SeatW'(inc);
    end else begin
      nbr_o = (base_i == '0) ? SeatW'(count_i - CountW'(1)) : (base_i - SeatW'(1));
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb import rfa_pkg::*; ();

  localparam int unsigned MaxSeats   = 16;
  localparam int unsigned SettleCyc  = 30;      // covers the release path and more
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SegWords   = 130;     // in-ring words per random segment

  typedef struct packed {
    kind_e          kind;
    logic [3:0]     seat;
  } word_t;

  typedef struct packed {
    logic [3:0]     seat;
    logic           last;
  } grant_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic [CfgWidth-1:0]  cfg_wdata_i   = '0;
  logic                 cfg_ready_o;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DataWidth-1:0] s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DataWidth-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  ring_fork_arbiter #(.MAX_SEATS(MaxSeats)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  word_t       word_q[$];
  grant_t      grant_q[$];
  word_t       cur_word;
  seat_state_e seat_st [MaxSeats];
  logic [CfgWidth-1:0] seats_cfg = SeatsReset;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned errors        = 0;
  int unsigned cycles        = 0;
  int unsigned words_taken   = 0;
  int unsigned words_ignored = 0;
  int unsigned grants_seen   = 0;
  int unsigned double_grants = 0;
  int unsigned cfg_writes    = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // effective ring size, register saturated to 2 .. MaxSeats
  function automatic int unsigned ring_size(input logic [CfgWidth-1:0] v);
    if (v < 2) return 2;
    if (v > MaxSeats) return MaxSeats;
    return 32'(v);
  endfunction

  // grant seat s when hungry and both ring neighbors are not eating
  function automatic void offer_forks(input int unsigned s, input int unsigned n,
                                      ref grant_t got[$]);
    grant_t g;
    if (seat_st[s] == SEAT_HUNGRY && seat_st[(s + n - 1) % n] != SEAT_EAT &&
        seat_st[(s + 1) % n] != SEAT_EAT) begin
      seat_st[s] = SEAT_EAT;
      g.seat = s[3:0];
      g.last = 1'b0;
      got.push_back(g);
    end
  endfunction

  // advance the seat table by one accepted word and queue the grants it causes
  function automatic void arbitrate_word(input word_t w);
    int unsigned n;
    int unsigned s;
    grant_t      got[$];
    n = ring_size(seats_cfg);
    s = 32'(w.seat);
    words_taken++;
    if (s >= n) begin
      words_ignored++;
      return;
    end
    if (w.kind == KIND_TAKE) begin
      seat_st[s] = SEAT_HUNGRY;
      offer_forks(s, n, got);
    end else begin
      seat_st[s] = SEAT_THINK;
      offer_forks((s + n - 1) % n, n, got);
      offer_forks((s + 1) % n, n, got);
    end
    if (got.size() != 0) got[got.size() - 1].last = 1'b1;
    if (got.size() == 2) double_grants++;
    foreach (got[i]) grant_q.push_back(got[i]);
  endfunction

  // driver: offers the next pending word when the slot is free, unless a random idle pause holds it
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) arbitrate_word(cur_word);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_word = word_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(DataWidth - 4){1'b0}}, cur_word.seat};
          s_axis_tuser  <= cur_word.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each grant word against the oldest expected grant
  always @(posedge clk_i) begin
    grant_t exp_g;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        grants_seen++;
        if (grant_q.size() == 0) begin
          $error("unexpected grant word: granted_seat %0d last %0d",
                 m_axis_tdata[3:0], m_axis_tlast);
          errors++;
        end else begin
          exp_g = grant_q.pop_front();
          if (m_axis_tdata[3:0] !== exp_g.seat) begin
            $error("granted_seat mismatch: expected %0d actual %0d",
                   exp_g.seat, m_axis_tdata[3:0]);
            errors++;
          end
          if (m_axis_tlast !== exp_g.last) begin
            $error("last mismatch: expected %0d actual %0d", exp_g.last, m_axis_tlast);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d grants still expected", cycles, grant_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_word(input kind_e k, input logic [3:0] s);
    word_t w;
    w.kind = k;
    w.seat = s;
    word_q.push_back(w);
  endtask

  // hold off until every word is taken and every grant has come, then let the block settle
  task automatic drain();
    @(posedge clk_i);
    while (word_q.size() != 0 || s_axis_tvalid || grant_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_seats(input logic [CfgWidth-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    seats_cfg = v;
    cfg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // random take/put mix, mostly inside the ring with some words aimed past it
  task automatic queue_random(input int unsigned count);
    int unsigned n;
    int unsigned placed;
    word_t       w;
    n = ring_size(seats_cfg);
    placed = 0;
    while (placed < count) begin
      w.kind = $urandom_range(1) ? KIND_PUT : KIND_TAKE;
      if ($urandom_range(99) < 12) w.seat = 4'($urandom_range(15));
      else w.seat = 4'($urandom_range(n - 1));
      if (w.seat < n) placed++;
      word_q.push_back(w);
    end
  endtask

  initial begin
    logic [CfgWidth-1:0] seg_cfg [10];
    seg_cfg = '{5'd0, 5'd31, 5'd3, 5'd1, 5'd17, 5'd7, 5'd16, 5'd12, 5'd5, 5'd4};
    foreach (seat_st[i]) seat_st[i] = SEAT_THINK;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full ring at reset size
    queue_word(KIND_TAKE, 4'd0);    // free seat eats at once
    queue_word(KIND_TAKE, 4'd1);    // neighbor eating, waits hungry
    queue_word(KIND_TAKE, 4'd15);   // wrap-around neighbor of seat 0
    queue_word(KIND_PUT,  4'd0);    // frees both sides: two grants
    queue_word(KIND_TAKE, 4'd1);    // request while already eating
    queue_word(KIND_PUT,  4'd5);    // release while thinking, nothing to grant
    queue_word(KIND_TAKE, 4'd14);
    queue_word(KIND_PUT,  4'd15);   // left neighbor granted, right one idle
    queue_word(KIND_PUT,  4'd1);
    queue_word(KIND_PUT,  4'd14);
    queue_word(KIND_TAKE, 4'd7);    // stays eating while the ring shrinks
    drain();

    // two seats: both neighbors are the same seat
    write_seats(5'd2);
    queue_word(KIND_TAKE, 4'd0);
    queue_word(KIND_TAKE, 4'd1);
    queue_word(KIND_PUT,  4'd0);    // seat 1 tested twice, granted once
    queue_word(KIND_TAKE, 4'd15);   // outside the ring
    queue_word(KIND_PUT,  4'd2);    // outside the ring
    queue_word(KIND_TAKE, 4'd0);
    queue_word(KIND_PUT,  4'd1);
    queue_word(KIND_PUT,  4'd0);
    drain();

    // random segments; idle pattern moves from sender-light to receiver-light to none
    for (int seg = 0; seg < 10; seg++) begin
      if (seg < 4) begin
        src_idle_pct  = 6;
        sink_idle_pct = 45;
      end else if (seg < 7) begin
        src_idle_pct  = 45;
        sink_idle_pct = 6;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      write_seats(seg_cfg[seg]);
      queue_random(SegWords);
      drain();
    end

    $display("%0d words (%0d outside the ring), %0d grants, %0d double grants",
             words_taken, words_ignored, grants_seen, double_grants);
    $display("%0d seat count writes, saturated values included", cfg_writes);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
